// File: hw/rtl/rth_pkg.sv
// Shared types, codes and constants for the rectangle hit-test table.
`default_nettype none

package rth_pkg;

  // Fixed field widths of the item and result formats.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned STATUS_W = 2;

  // Default table depth and coordinate width.
  localparam int unsigned MAX_RECTS_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Action codes carried by an input item.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_POINT  = 3'd3,
    ACT_BOX    = 3'd4
  } action_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the input item
    logic res_clr;    // clear the result fields
    logic idx_zero;   // start the table index at the first entry
    logic idx_slot1;  // start the table index one past the removed slot
    logic rd_en;      // read the entry at the index and advance it
    logic scan;       // compare read entries against the item
    logic shift;      // write read entries back one place lower
    logic wr_insert;  // append the item's rectangle at the tail
    logic set_full;   // report a full table
    logic set_bad;    // report a slot that is not held
    logic cnt_dec;    // one entry fewer
    logic out_load;   // move the result into the output register
  } rth_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;     // action of the latched item
    logic    table_full; // every slot is held
    logic    slot_bad;   // removal slot lies at or beyond the count
    logic    more;       // index still points at a held entry
    logic    rd_pend;    // a read result is on its way
    logic    hit_now;    // the entry read last matches the item
    logic    out_free;   // the output register can take a result
  } rth_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/rth_ctrl.sv
// Controller state machine that sequences insert, remove, find and queries.
`default_nettype none

module rth_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  rth_pkg::rth_stat_t stat_i,
  output rth_pkg::rth_cmd_t  cmd_o
);
  import rth_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_clr = 1'b1;
        unique case (stat_i.action) inside
          ACT_INSERT: begin
            if (stat_i.table_full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.wr_insert = 1'b1;
            end
            state_d = S_RESULT;
          end
          ACT_REMOVE: begin
            if (stat_i.slot_bad) begin
              cmd_o.set_bad = 1'b1;
              state_d       = S_RESULT;
            end else begin
              cmd_o.idx_slot1 = 1'b1;
              state_d         = S_SHIFT;
            end
          end
          ACT_FIND, ACT_POINT, ACT_BOX: begin
            cmd_o.idx_zero = 1'b1;
            state_d        = S_SCAN;
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan  = 1'b1;
        cmd_o.rd_en = stat_i.more;
        if (stat_i.hit_now || (!stat_i.more && !stat_i.rd_pend)) begin
          state_d = S_RESULT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.rd_en = stat_i.more;
        if (!stat_i.more && !stat_i.rd_pend) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A result only moves out when the output register has room.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded into a full output register");

  // A new item is taken only after the previous result left for the output.
  a_accept_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.capture) |-> ($past(state_q) == S_RESULT || $past(state_q) == S_IDLE))
    else $error("item accepted while a previous item was in progress");

endmodule

`default_nettype wire

// File: hw/rtl/rth_datapath.sv
// Datapath: rectangle memory, item registers, compare logic and output register.
`default_nettype none

module rth_datapath #(
  parameter int unsigned MAX_RECTS  = rth_pkg::MAX_RECTS_DEF,
  parameter int unsigned COORD_BITS = rth_pkg::COORD_BITS_DEF,
  parameter int unsigned IN_W       = 72,
  parameter int unsigned OUT_W      = 16
) (
  input  wire                rst_ni,
  input  wire                clk_i,
  input  wire  [IN_W-1:0]    s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  wire                m_axis_tready_i,
  output logic [OUT_W-1:0]   m_axis_tdata_o,
  input  rth_pkg::rth_cmd_t  cmd_i,
  output rth_pkg::rth_stat_t stat_o
);
  import rth_pkg::*;

  localparam int unsigned CW       = COORD_BITS;
  localparam int unsigned SLOT_W   = $clog2(MAX_RECTS);
  localparam int unsigned COUNT_W  = $clog2(MAX_RECTS + 1);
  localparam int unsigned EW       = (CW > SIZE_W) ? CW + 1 : SIZE_W + 2;
  localparam int unsigned ENT_W    = 2 * CW + 2 * EW;
  localparam int unsigned OUT_BITS = 1 + SLOT_W + COUNT_W + STATUS_W;
  // Item field offsets in tdata.
  localparam int unsigned OFF_X    = ACTION_W;
  localparam int unsigned OFF_Y    = OFF_X + CW;
  localparam int unsigned OFF_W    = OFF_Y + CW;
  localparam int unsigned OFF_H    = OFF_W + SIZE_W;
  localparam int unsigned OFF_SLOT = OFF_H + SIZE_W;
  // Entry field offsets in a memory word.
  localparam int unsigned E_BOT    = CW;
  localparam int unsigned E_RIGHT  = 2 * CW;
  localparam int unsigned E_TOP    = 2 * CW + EW;

  // Latched item.
  action_e              act_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [EW-1:0] xw_q, yh_q;
  logic [SLOT_W-1:0]    slot_q;

  // Table state and scan control.
  logic [ENT_W-1:0]     mem [MAX_RECTS];
  logic [ENT_W-1:0]     rdata_q;
  logic                 rd_valid_q;
  logic [SLOT_W-1:0]    rd_tag_q;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   idx_q;

  // Result and output registers.
  logic                 hit_q;
  logic [SLOT_W-1:0]    res_slot_q;
  status_e              status_q;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q;

  logic signed [CW-1:0] in_x, in_y;
  logic [SIZE_W-1:0]    in_w, in_h;

  assign in_x = s_axis_tdata_i[OFF_X +: CW];
  assign in_y = s_axis_tdata_i[OFF_Y +: CW];
  assign in_w = s_axis_tdata_i[OFF_W +: SIZE_W];
  assign in_h = s_axis_tdata_i[OFF_H +: SIZE_W];

  // Item capture; the box's far edges are formed here once.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_e'(s_axis_tdata_i[ACTION_W-1:0]);
      x_q    <= in_x;
      y_q    <= in_y;
      xw_q   <= EW'(in_x) + $signed({{(EW - SIZE_W){1'b0}}, in_w});
      yh_q   <= EW'(in_y) - $signed({{(EW - SIZE_W){1'b0}}, in_h});
      slot_q <= s_axis_tdata_i[OFF_SLOT +: SLOT_W];
    end
  end

  // Memory write: append on insert, or move an entry down one place on remove.
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]   mem_wdata;

  assign mem_we    = cmd_i.wr_insert | (cmd_i.shift & rd_valid_q);
  assign mem_waddr = cmd_i.wr_insert ? count_q[SLOT_W-1:0] : (rd_tag_q - SLOT_W'(1));
  assign mem_wdata = cmd_i.wr_insert ? {yh_q, xw_q, y_q, x_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_q[SLOT_W-1:0]];
    end
  end

  // Read tag follows the registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_tag_q <= idx_q[SLOT_W-1:0];
    end
  end

  // Index, count and read-pending flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      count_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      if (cmd_i.idx_zero) begin
        idx_q <= '0;
      end else if (cmd_i.idx_slot1) begin
        idx_q <= COUNT_W'(slot_q) + COUNT_W'(1);
      end else if (cmd_i.rd_en) begin
        idx_q <= idx_q + COUNT_W'(1);
      end
      if (cmd_i.wr_insert) begin
        count_q <= count_q + COUNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - COUNT_W'(1);
      end
    end
  end

  // Compare the entry just read against the latched item.
  logic signed [CW-1:0] e_left, e_bot;
  logic signed [EW-1:0] e_right, e_top, le, be, xe, ye;
  logic                 m;

  assign e_left  = rdata_q[0 +: CW];
  assign e_bot   = rdata_q[E_BOT +: CW];
  assign e_right = rdata_q[E_RIGHT +: EW];
  assign e_top   = rdata_q[E_TOP +: EW];
  assign le      = EW'(e_left);
  assign be      = EW'(e_bot);
  assign xe      = EW'(x_q);
  assign ye      = EW'(y_q);

  always_comb begin
    case (act_q)
      ACT_FIND:  m = (e_left == x_q) && (e_bot == y_q);
      ACT_POINT: m = (xe >= le) && (xe <= e_right) && (ye >= e_top) && (ye <= be);
      ACT_BOX:   m = (le <= xw_q) && (e_right >= xe) && (ye > e_top) && (yh_q < be);
      default:   m = 1'b0;
    endcase
  end

  logic hit_now;
  assign hit_now = cmd_i.scan & rd_valid_q & m;

  // Result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      res_slot_q <= '0;
      status_q   <= ST_OK;
    end else begin
      if (cmd_i.res_clr) begin
        hit_q      <= 1'b0;
        res_slot_q <= '0;
        status_q   <= ST_OK;
      end
      if (cmd_i.wr_insert) begin
        res_slot_q <= count_q[SLOT_W-1:0];
      end
      if (cmd_i.set_full) begin
        status_q <= ST_FULL;
      end
      if (cmd_i.set_bad) begin
        status_q <= ST_BAD_SLOT;
      end
      if (hit_now && !hit_q) begin
        hit_q      <= 1'b1;
        res_slot_q <= rd_tag_q;
      end
    end
  end

  // Output register: holds a finished result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= OUT_W'({status_q, count_q, res_slot_q, hit_q});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Status to the controller.
  assign stat_o.action     = act_q;
  assign stat_o.table_full = (count_q == COUNT_W'(MAX_RECTS));
  assign stat_o.slot_bad   = (COUNT_W'(slot_q) >= count_q);
  assign stat_o.more       = (idx_q < count_q);
  assign stat_o.rd_pend    = rd_valid_q;
  assign stat_o.hit_now    = hit_now;
  assign stat_o.out_free   = !out_valid_q || m_axis_tready_i;

  // The count never passes the table depth.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(MAX_RECTS))
    else $error("entry count beyond table depth");

  // An append only happens into a free slot.
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_insert |-> (count_q < COUNT_W'(MAX_RECTS)))
    else $error("append into a full table");

  // A moved entry comes from a held slot above the removed one.
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && rd_valid_q) |-> (rd_tag_q != '0 && COUNT_W'(rd_tag_q) < count_q))
    else $error("shift write outside the held entries");

  // The output register is only refilled after its result is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> out_valid_q)
    else $error("unread result dropped from output register");

  // The OUT_BITS packing must fit the output port.
  a_out_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (OUT_W >= OUT_BITS))
    else $error("result does not fit the output data bus");

endmodule

`default_nettype wire

// File: hw/rtl/rect_table_hit_tester.sv
// Top level of the rectangle hit-test table: stream ports, controller and datapath.
// Insert, failed remove and unknown actions go from decode straight to the result state;
// a remove moves the n = count - 1 - s entries above slot s down one place each.
// Find and queries scan from slot 0 and stop at the first match, or read all held entries
// when none matches. Throughput: one item at a time, accepted in the cycle after the previous
// result is loaded; the table scan sets the item time. Reset empties the table.
`default_nettype none

module rect_table_hit_tester #(
  parameter int unsigned MAX_RECTS  = rth_pkg::MAX_RECTS_DEF,
  parameter int unsigned COORD_BITS = rth_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_BITS  = rth_pkg::ACTION_W + 2 * COORD_BITS
                                     + 2 * rth_pkg::SIZE_W + $clog2(MAX_RECTS),
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = 1 + $clog2(MAX_RECTS) + $clog2(MAX_RECTS + 1)
                                     + rth_pkg::STATUS_W,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // action, pos_x, pos_y, size_w, size_h, slot_in (lowest bits first), zero padded
  input  wire  [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire              m_axis_tready_i,
  // hit, hit_slot, entry_count, status (lowest bits first), zero padded
  output logic [OUT_W-1:0] m_axis_tdata_o
);
  import rth_pkg::*;

  rth_cmd_t  cmd;
  rth_stat_t stat;

  // Sequencer.
  rth_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  // Table storage and compare logic.
  rth_datapath #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) u_datapath (
    .rst_ni          (rst_ni),
    .clk_i           (clk_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

`default_nettype wire
